### rtl/gsoc_pkg.sv
// Shared types and constants of the grid segment obstacle checker.
// Used by the controller, the datapath, the divider and the top level.
package gsoc_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int COORD_W    = 8;   // request coordinates
    localparam int WALK_W     = 12;  // signed walk coordinates, room for overshoot
    localparam int SIZE_W     = 9;   // map size registers
    localparam int CELL_W     = 8;
    localparam int DIVD_W     = 16;  // |minor delta| * step
    localparam int DIVS_W     = 8;   // major delta
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CELL_W-1:0]  CELL_RESET      = 8'd255;
    localparam logic [CELL_W-1:0]  LINE_THR_RESET  = 8'd200;
    localparam logic [CELL_W-1:0]  POINT_THR_RESET = 8'd255;
    localparam logic [7:0]         STEP_RESET      = 8'd1;
    localparam logic [SIZE_W-1:0]  SIZE_RESET      = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_THR   = 3'd4;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_SEGMENT = 2'd1,
        OP_POINT   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_POINT,
        ST_DIV_GO,
        ST_DIV,
        ST_FIX,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic accept;
        logic clear_run;
        logic mem_write;
        logic probe_walk;
        logic seg_load;
        logic div_start;
        logic fix_load;
        logic walk_adv;
        logic finish;
        logic finish_clear;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic clear_last;
        logic probe_in_map;
        logic ends_equal;
        logic div_done;
        logic walk_go;
        logic line_hit;
        logic point_ok;
    } status_t;

endpackage

### rtl/gsoc_div.sv
// Restoring divider, one quotient bit per cycle, for the segment slope.
// Depends on gsoc_pkg for the operand widths.
module gsoc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gsoc_pkg::DIVD_W-1:0]   dividend,
    input  logic [gsoc_pkg::DIVS_W-1:0]   divisor,
    output logic                          done,
    output logic [gsoc_pkg::DIVD_W-1:0]   quotient,
    output logic [gsoc_pkg::DIVS_W-1:0]   remainder
);

    localparam int DW    = gsoc_pkg::DIVD_W;
    localparam int SW    = gsoc_pkg::DIVS_W;
    localparam int CNT_W = $clog2(DW);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    quo_reg;
    logic [SW-1:0]    rem_reg;

    logic [SW:0]      rem_shift;
    logic [SW:0]      rem_sub;
    logic             ge;

    assign rem_shift = {rem_reg, quo_reg[DW-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor};
    assign ge        = (rem_shift >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= ge ? rem_sub[SW-1:0] : rem_shift[SW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### rtl/gsoc_datapath.sv
// Datapath: configuration registers, occupancy map memory, segment walk
// registers and result registers. Depends on gsoc_pkg and gsoc_div.
module gsoc_datapath #(
    parameter int MAX_WIDTH  = gsoc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gsoc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gsoc_pkg::cmd_t                    cmd,
    output gsoc_pkg::status_t                 sts,
    input  logic [1:0]                        op,
    input  logic [gsoc_pkg::COORD_W-1:0]      first_x,
    input  logic [gsoc_pkg::COORD_W-1:0]      first_y,
    input  logic [gsoc_pkg::COORD_W-1:0]      second_x,
    input  logic [gsoc_pkg::COORD_W-1:0]      second_y,
    input  logic [gsoc_pkg::CELL_W-1:0]       cell_value,
    input  logic                              cfg_write,
    input  logic [gsoc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gsoc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              done,
    output logic                              is_clear
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = gsoc_pkg::WALK_W;
    localparam int NW    = gsoc_pkg::COORD_W;
    localparam int SW    = gsoc_pkg::SIZE_W;
    localparam int LW    = SW + 1;   // columns or rows in use, up to 511

    // Configuration.
    logic [SW-1:0]   map_width_reg;
    logic [SW-1:0]   map_height_reg;
    logic [7:0]      check_step_reg;
    logic [7:0]      line_thr_reg;
    logic [7:0]      point_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= gsoc_pkg::SIZE_RESET;
            map_height_reg <= gsoc_pkg::SIZE_RESET;
            check_step_reg <= gsoc_pkg::STEP_RESET;
            line_thr_reg   <= gsoc_pkg::LINE_THR_RESET;
            point_thr_reg  <= gsoc_pkg::POINT_THR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gsoc_pkg::REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                gsoc_pkg::REG_MAP_HEIGHT: map_height_reg <= cfg_data;
                gsoc_pkg::REG_CHECK_STEP: check_step_reg <= cfg_data[7:0];
                gsoc_pkg::REG_LINE_THR:   line_thr_reg   <= cfg_data[7:0];
                gsoc_pkg::REG_POINT_THR:  point_thr_reg  <= cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    logic [LW-1:0] cols;
    logic [LW-1:0] rows;

    // A limit above the largest register value never applies.
    assign cols = (32'(map_width_reg) < 32'(MAX_WIDTH)) ? {1'b0, map_width_reg}
                                                        : LW'(MAX_WIDTH);
    assign rows = (32'(map_height_reg) < 32'(MAX_HEIGHT)) ? {1'b0, map_height_reg}
                                                          : LW'(MAX_HEIGHT);

    // Request capture.
    gsoc_pkg::op_t   req_op_reg;
    logic [NW-1:0]   req_fx_reg;
    logic [NW-1:0]   req_fy_reg;
    logic [NW-1:0]   req_sx_reg;
    logic [NW-1:0]   req_sy_reg;
    logic [7:0]      req_value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_op_reg    <= gsoc_pkg::op_t'(op);
            req_fx_reg    <= first_x;
            req_fy_reg    <= first_y;
            req_sx_reg    <= second_x;
            req_sy_reg    <= second_y;
            req_value_reg <= cell_value;
        end
    end

    // Segment geometry from the captured endpoints.
    logic signed [NW:0] dx;
    logic signed [NW:0] dy;
    logic [NW-1:0]      adx;
    logic [NW-1:0]      ady;
    logic               x_major;
    logic [NW-1:0]      sa, sb, ma, mb;
    logic               fwd;
    logic [NW-1:0]      s0, s1, m0, m1;
    logic [NW-1:0]      dmaj;
    logic               dmin_neg;
    logic [NW-1:0]      dmin_mag;
    logic [7:0]         step_eff;

    always_comb
    begin
        dx       = $signed({1'b0, req_fx_reg}) - $signed({1'b0, req_sx_reg});
        dy       = $signed({1'b0, req_fy_reg}) - $signed({1'b0, req_sy_reg});
        adx      = dx[NW] ? NW'(-dx) : NW'(dx);
        ady      = dy[NW] ? NW'(-dy) : NW'(dy);
        x_major  = (adx > ady);
        sa       = x_major ? req_fx_reg : req_fy_reg;
        sb       = x_major ? req_sx_reg : req_sy_reg;
        ma       = x_major ? req_fy_reg : req_fx_reg;
        mb       = x_major ? req_sy_reg : req_sx_reg;
        fwd      = (sa < sb);
        s0       = fwd ? sa : sb;
        s1       = fwd ? sb : sa;
        m0       = fwd ? ma : mb;
        m1       = fwd ? mb : ma;
        dmaj     = s1 - s0;
        dmin_neg = (m1 < m0);
        dmin_mag = dmin_neg ? (m0 - m1) : (m1 - m0);
        step_eff = (check_step_reg == 8'd0) ? 8'd1 : check_step_reg;
    end

    // Walk registers.
    logic                 xmaj_reg;
    logic [NW:0]          limit_reg;
    logic [NW-1:0]        dmaj_reg;
    logic                 dneg_reg;
    logic [NW-1:0]        dmag_reg;
    logic [7:0]           step_reg;
    logic signed [CW-1:0] major_reg;
    logic signed [CW-1:0] minor_reg;
    logic [NW-1:0]        rem_reg;
    logic signed [CW-1:0] q_reg;
    logic [NW-1:0]        r_reg;

    // Slope quotient and remainder.
    logic                               div_done;
    logic [gsoc_pkg::DIVD_W-1:0]        div_quo;
    logic [gsoc_pkg::DIVS_W-1:0]        div_rem;
    logic [gsoc_pkg::DIVD_W-1:0]        product;

    assign product = gsoc_pkg::DIVD_W'(dmag_reg * step_reg);

    gsoc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (product),
        .divisor   (dmaj_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Floor correction for a negative minor delta: -q-1 with remainder
    // dmaj-r when the division is inexact, -q otherwise.
    logic                 rm_nz;
    logic signed [CW-1:0] qpos;
    logic signed [CW-1:0] q_fix;
    logic [NW-1:0]        r_fix;

    always_comb
    begin
        rm_nz = (div_rem != '0);
        qpos  = $signed({{(CW-NW){1'b0}}, div_quo[NW-1:0]});
        if (dneg_reg)
        begin
            q_fix = ~qpos + CW'(!rm_nz);
            r_fix = rm_nz ? (dmaj_reg - div_rem) : '0;
        end
        else
        begin
            q_fix = qpos;
            r_fix = div_rem;
        end
    end

    logic [NW:0]          rsum;
    logic                 carry;
    logic [NW-1:0]        rem_next;
    logic signed [CW-1:0] minor_next;
    logic signed [CW-1:0] major_next;

    always_comb
    begin
        rsum       = {1'b0, rem_reg} + {1'b0, r_reg};
        carry      = (rsum >= {1'b0, dmaj_reg});
        rem_next   = carry ? NW'(rsum - {1'b0, dmaj_reg}) : rsum[NW-1:0];
        minor_next = minor_reg + q_reg + CW'(carry);
        major_next = major_reg + $signed({{(CW-8){1'b0}}, step_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seg_load)
        begin
            xmaj_reg  <= x_major;
            limit_reg <= {1'b0, s1} + {1'b0, step_eff};
            dmaj_reg  <= dmaj;
            dneg_reg  <= dmin_neg;
            dmag_reg  <= dmin_mag;
            step_reg  <= step_eff;
            major_reg <= $signed({{(CW-NW){1'b0}}, s0});
            minor_reg <= $signed({{(CW-NW){1'b0}}, m0});
            rem_reg   <= '0;
        end
        else if (cmd.walk_adv)
        begin
            major_reg <= major_next;
            minor_reg <= minor_next;
            rem_reg   <= rem_next;
        end
        if (cmd.fix_load)
        begin
            q_reg <= q_fix;
            r_reg <= r_fix;
        end
    end

    // Probe point: the walk position or the captured first point.
    logic signed [CW-1:0] probe_x;
    logic signed [CW-1:0] probe_y;
    logic                 probe_in_map;
    logic                 in_range;
    logic [AW-1:0]        addr;

    always_comb
    begin
        if (cmd.probe_walk)
        begin
            probe_x = xmaj_reg ? major_reg : minor_reg;
            probe_y = xmaj_reg ? minor_reg : major_reg;
        end
        else
        begin
            probe_x = $signed({{(CW-NW){1'b0}}, req_fx_reg});
            probe_y = $signed({{(CW-NW){1'b0}}, req_fy_reg});
        end
        probe_in_map = !probe_x[CW-1] && !probe_y[CW-1]
                       && (probe_x[CW-2:0] < {{(CW-1-LW){1'b0}}, cols})
                       && (probe_y[CW-2:0] < {{(CW-1-LW){1'b0}}, rows});
        in_range     = (major_reg[CW-2:0] < {{(CW-2-NW){1'b0}}, limit_reg});
        addr         = AW'(32'(probe_x[CW-2:0]) * 32'(MAX_HEIGHT)
                           + 32'(probe_y[CW-2:0]));
    end

    // Occupancy map with a clearing pass after reset.
    logic [AW-1:0]  clr_addr_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [7:0]     mem [DEPTH];
    logic [7:0]     rd_data_reg;
    logic           rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_run)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            rd_valid_reg <= cmd.walk_adv;
        end
    end

    assign mem_we    = cmd.clear_run || (cmd.mem_write && probe_in_map);
    assign mem_waddr = cmd.clear_run ? clr_addr_reg : addr;
    assign mem_wdata = cmd.clear_run ? gsoc_pkg::CELL_RESET : req_value_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr];
    end

    // Result registers.
    logic done_reg;
    logic is_clear_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            is_clear_reg <= cmd.finish_clear;
        end
    end

    assign done     = done_reg;
    assign is_clear = is_clear_reg;

    always_comb
    begin
        sts.op           = req_op_reg;
        sts.clear_last   = (clr_addr_reg == AW'(DEPTH - 1));
        sts.probe_in_map = probe_in_map;
        sts.ends_equal   = (req_fx_reg == req_sx_reg) && (req_fy_reg == req_sy_reg);
        sts.div_done     = div_done;
        sts.walk_go      = probe_in_map && in_range;
        sts.line_hit     = rd_valid_reg && (rd_data_reg < line_thr_reg);
        sts.point_ok     = (rd_data_reg >= point_thr_reg);
    end

endmodule

### rtl/gsoc_ctrl.sv
// Controller state machine: sequences map clearing, request dispatch,
// slope division and the cell walk. Depends on gsoc_pkg.
module gsoc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output gsoc_pkg::cmd_t     cmd,
    input  gsoc_pkg::status_t  sts
);

    gsoc_pkg::state_t state_reg;
    gsoc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsoc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            gsoc_pkg::ST_CLEAR:
            begin
                cmd.clear_run = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = gsoc_pkg::ST_IDLE;
                end
            end
            gsoc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = gsoc_pkg::ST_DISPATCH;
                end
            end
            gsoc_pkg::ST_DISPATCH:
            begin
                case (sts.op)
                    gsoc_pkg::OP_WRITE:
                    begin
                        cmd.mem_write    = 1'b1;
                        cmd.finish       = 1'b1;
                        cmd.finish_clear = 1'b1;
                        state_next       = gsoc_pkg::ST_IDLE;
                    end
                    gsoc_pkg::OP_POINT:
                    begin
                        // The cell is read in this cycle when the point is on the map.
                        if (sts.probe_in_map)
                        begin
                            state_next = gsoc_pkg::ST_POINT;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            state_next = gsoc_pkg::ST_IDLE;
                        end
                    end
                    gsoc_pkg::OP_SEGMENT:
                    begin
                        if (sts.ends_equal)
                        begin
                            cmd.finish       = 1'b1;
                            cmd.finish_clear = 1'b1;
                            state_next       = gsoc_pkg::ST_IDLE;
                        end
                        else
                        begin
                            cmd.seg_load = 1'b1;
                            state_next   = gsoc_pkg::ST_DIV_GO;
                        end
                    end
                    default:
                    begin
                        cmd.finish       = 1'b1;
                        cmd.finish_clear = 1'b1;
                        state_next       = gsoc_pkg::ST_IDLE;
                    end
                endcase
            end
            gsoc_pkg::ST_POINT:
            begin
                cmd.finish       = 1'b1;
                cmd.finish_clear = sts.point_ok;
                state_next       = gsoc_pkg::ST_IDLE;
            end
            gsoc_pkg::ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = gsoc_pkg::ST_DIV;
            end
            gsoc_pkg::ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = gsoc_pkg::ST_FIX;
                end
            end
            gsoc_pkg::ST_FIX:
            begin
                cmd.fix_load = 1'b1;
                state_next   = gsoc_pkg::ST_WALK;
            end
            gsoc_pkg::ST_WALK:
            begin
                // The read issued last cycle is checked while the next one goes out.
                cmd.probe_walk = 1'b1;
                if (sts.line_hit)
                begin
                    cmd.finish = 1'b1;
                    state_next = gsoc_pkg::ST_IDLE;
                end
                else if (!sts.walk_go)
                begin
                    cmd.finish       = 1'b1;
                    cmd.finish_clear = 1'b1;
                    state_next       = gsoc_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                end
            end
            default:
            begin
                state_next = gsoc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != gsoc_pkg::ST_IDLE);

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gsoc_pkg::ST_IDLE && start) |=> state_reg == gsoc_pkg::ST_DISPATCH)
        else $error("accepted request did not reach dispatch");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == gsoc_pkg::ST_IDLE))
        else $error("controller not idle after a result");

    a_walk_adv_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_adv |-> (sts.walk_go && !sts.line_hit))
        else $error("walk advanced past a blocked or outside cell");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gsoc_pkg::ST_DIV && !sts.div_done) |=> state_reg == gsoc_pkg::ST_DIV)
        else $error("left divide wait before the quotient was ready");

endmodule

### rtl/grid_segment_obstacle_check.sv
// Occupancy-map obstacle checker: cell writes, point tests, segment tests.
// A segment test runs a slope division, then one map read per visited cell
// (up to 256 cells); a request is taken while the done strobe of the previous
// one is up. After reset the map is cleared to 255, one cell a cycle, over all
// MAX_WIDTH * MAX_HEIGHT cells with busy high.
module grid_segment_obstacle_check #(
    parameter int MAX_WIDTH  = gsoc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gsoc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        op,
    input  logic [gsoc_pkg::COORD_W-1:0]      first_x,
    input  logic [gsoc_pkg::COORD_W-1:0]      first_y,
    input  logic [gsoc_pkg::COORD_W-1:0]      second_x,
    input  logic [gsoc_pkg::COORD_W-1:0]      second_y,
    input  logic [gsoc_pkg::CELL_W-1:0]       cell_value,
    input  logic                              cfg_write,
    input  logic [gsoc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gsoc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              done,
    output logic                              is_clear
);

    gsoc_pkg::cmd_t    cmd;
    gsoc_pkg::status_t sts;

    gsoc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    gsoc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .op         (op),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y),
        .cell_value (cell_value),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .is_clear   (is_clear)
    );

endmodule

### bench/tb_grid_segment_obstacle_check.sv
// Self-checking testbench for grid_segment_obstacle_check: cell writes, point and segment tests.
// Depends on gsoc_pkg and the grid_segment_obstacle_check RTL; it reads no files.
module tb_grid_segment_obstacle_check;
    timeunit 1ns;
    timeprecision 1ps;

    import gsoc_pkg::*;

    localparam int GRID_W = MAX_WIDTH_DEF;
    localparam int GRID_H = MAX_HEIGHT_DEF;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [CELL_W-1:0]  value;
    } grid_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            op = OP_WRITE;
    logic [COORD_W-1:0]    first_x = '0;
    logic [COORD_W-1:0]    first_y = '0;
    logic [COORD_W-1:0]    second_x = '0;
    logic [COORD_W-1:0]    second_y = '0;
    logic [CELL_W-1:0]     cell_value = '0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MAP_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  done;
    logic                  is_clear;

    grid_req_t req_pending_q[$];
    bit        clear_expected_q[$];

    // Mirror of the occupancy map and of the register file.
    logic [CELL_W-1:0] occ_model [0:GRID_W*GRID_H-1];
    int cfg_width     = int'(SIZE_RESET);
    int cfg_height    = int'(SIZE_RESET);
    int cfg_step      = int'(STEP_RESET);
    int cfg_line_thr  = int'(LINE_THR_RESET);
    int cfg_point_thr = int'(POINT_THR_RESET);

    int   fail_count = 0;
    int   n_writes = 0;
    int   n_points = 0;
    int   n_points_clear = 0;
    int   n_segments = 0;
    int   n_segments_clear = 0;
    int   n_unused = 0;
    int   n_settings = 0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   stall_cycles = 0;
    logic req_taken = 1'b0;

    grid_segment_obstacle_check #(
        .MAX_WIDTH  (GRID_W),
        .MAX_HEIGHT (GRID_H)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y),
        .cell_value (cell_value),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .is_clear   (is_clear)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int cols_used();
        return (cfg_width < GRID_W) ? cfg_width : GRID_W;
    endfunction

    function automatic int rows_used();
        return (cfg_height < GRID_H) ? cfg_height : GRID_H;
    endfunction

    function automatic bit cell_in_map(input int x, input int y);
        return x >= 0 && y >= 0 && x < cols_used() && y < rows_used();
    endfunction

    function automatic int cell_index(input int x, input int y);
        return x * GRID_H + y;
    endfunction

    function automatic int floor_quot(input int num, input int den);
        int q;
        q = num / den;
        if (num < 0 && q * den != num)
        begin
            q--;
        end
        return q;
    endfunction

    // Walks the major axis from the endpoint with the lower major coordinate.
    function automatic bit segment_is_clear(input int ax, input int ay, input int bx, input int by);
        int adx, ady, sa, sb, ma, mb, s0, s1, m0, dmin, dmaj, stride, off, major, minor, x, y;
        bit x_major;
        if (ax == bx && ay == by)
        begin
            return 1'b1;
        end
        adx = (ax > bx) ? ax - bx : bx - ax;
        ady = (ay > by) ? ay - by : by - ay;
        x_major = adx > ady;
        sa = x_major ? ax : ay;
        sb = x_major ? bx : by;
        ma = x_major ? ay : ax;
        mb = x_major ? by : bx;
        if (sa < sb)
        begin
            s0 = sa;
            s1 = sb;
            m0 = ma;
            dmin = mb - ma;
        end
        else
        begin
            s0 = sb;
            s1 = sa;
            m0 = mb;
            dmin = ma - mb;
        end
        dmaj = s1 - s0;
        stride = (cfg_step == 0) ? 1 : cfg_step;
        for (off = 0; s0 + off < s1 + stride; off += stride)
        begin
            major = s0 + off;
            minor = m0 + floor_quot(dmin * off, dmaj);
            x = x_major ? major : minor;
            y = x_major ? minor : major;
            if (!cell_in_map(x, y))
            begin
                return 1'b1;
            end
            if (occ_model[cell_index(x, y)] < cfg_line_thr)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Computes the answer for one request and applies a write to the map mirror.
    function automatic bit predict_clear(input grid_req_t r);
        bit clear;
        clear = 1'b1;
        case (r.op)
            OP_WRITE:
            begin
                if (cell_in_map(r.fx, r.fy))
                begin
                    occ_model[cell_index(r.fx, r.fy)] = r.value;
                end
            end
            OP_SEGMENT:
            begin
                clear = segment_is_clear(r.fx, r.fy, r.sx, r.sy);
            end
            OP_POINT:
            begin
                clear = cell_in_map(r.fx, r.fy) && occ_model[cell_index(r.fx, r.fy)] >= cfg_point_thr;
            end
            default:
            begin
            end
        endcase
        return clear;
    endfunction

    function automatic int new_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            return 0;
        end
        return (r < 8) ? int'($urandom_range(1, 4)) : int'($urandom_range(5, 30));
    endfunction

    function automatic int rand_coord(input int lim);
        if (lim <= 0 || $urandom_range(0, 6) == 0)
        begin
            return $urandom_range(0, 255);
        end
        // The upper bound is one past the last cell in use when the map is small.
        return $urandom_range(0, (lim > 255) ? 255 : lim);
    endfunction

    function automatic int pick_value(input int thr);
        int v;
        if ($urandom_range(0, 1) == 1)
        begin
            return $urandom_range(0, 255);
        end
        v = thr + int'($urandom_range(0, 4)) - 2;
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    task automatic push_req(input logic [1:0] code, input int fx, input int fy, input int sx,
                            input int sy, input int value);
        grid_req_t r;
        r.op = code;
        r.fx = fx[7:0];
        r.fy = fy[7:0];
        r.sx = sx[7:0];
        r.sy = sy[7:0];
        r.value = value[7:0];
        req_pending_q = {req_pending_q, r};
    endtask

    // Driver: requests go out in bursts, with gaps between bursts.
    always @(negedge clk)
    begin
        grid_req_t nxt;
        logic drive_start;
        drive_start = start;
        if (rst_n && (!start || req_taken))
        begin
            drive_start = 1'b0;
            if (start)
            begin
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = new_gap();
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (req_pending_q.size() != 0)
            begin
                nxt = req_pending_q.pop_front();
                op <= nxt.op;
                first_x <= nxt.fx;
                first_y <= nxt.fy;
                second_x <= nxt.sx;
                second_y <= nxt.sy;
                cell_value <= nxt.value;
                drive_start = 1'b1;
            end
        end
        start <= drive_start;
    end

    // Monitor: checks each result against the oldest prediction, then logs new requests.
    always @(posedge clk)
    begin
        grid_req_t taken;
        bit want;
        if (done)
        begin
            if (clear_expected_q.size() == 0)
            begin
                $error("result with no request outstanding: is_clear=%0b", is_clear);
                fail_count++;
            end
            else
            begin
                want = clear_expected_q.pop_front();
                if (is_clear !== want)
                begin
                    $error("is_clear mismatch: expected %0b, actual %0b", want, is_clear);
                    fail_count++;
                end
            end
        end
        if (start && !busy)
        begin
            taken.op = op;
            taken.fx = first_x;
            taken.fy = first_y;
            taken.sx = second_x;
            taken.sy = second_y;
            taken.value = cell_value;
            want = predict_clear(taken);
            clear_expected_q = {clear_expected_q, want};
            case (taken.op)
                OP_WRITE:   n_writes++;
                OP_SEGMENT:
                begin
                    n_segments++;
                    n_segments_clear += want;
                end
                OP_POINT:
                begin
                    n_points++;
                    n_points_clear += want;
                end
                default:    n_unused++;
            endcase
        end
        req_taken <= start && !busy;
    end

    // The first stretch covers the map clearing pass after reset.
    always @(posedge clk)
    begin
        if (done || (start && !busy))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $error("no request or result for %0d cycles", STALL_LIMIT);
            $display("tb_grid_segment_obstacle_check failed");
            $finish;
        end
    end

    task automatic wait_for_drain();
        while (req_pending_q.size() != 0 || start || clear_expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic program_map_config(input int w, input int h, input int s, input int lt,
                                      input int pt);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_MAP_WIDTH;
        cfg_data <= w[8:0];
        cfg_width = w & 'h1FF;
        @(negedge clk);
        cfg_index <= REG_MAP_HEIGHT;
        cfg_data <= h[8:0];
        cfg_height = h & 'h1FF;
        @(negedge clk);
        cfg_index <= REG_CHECK_STEP;
        cfg_data <= s[8:0];
        cfg_step = s & 'hFF;
        @(negedge clk);
        cfg_index <= REG_LINE_THR;
        cfg_data <= lt[8:0];
        cfg_line_thr = lt & 'hFF;
        @(negedge clk);
        cfg_index <= REG_POINT_THR;
        cfg_data <= pt[8:0];
        cfg_point_thr = pt & 'hFF;
        @(negedge clk);
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    task automatic plan_directed();
        push_req(OP_WRITE, 0, 0, 0, 0, 0);
        push_req(OP_POINT, 0, 0, 0, 0, 0);
        push_req(OP_POINT, 255, 255, 0, 0, 0);
        push_req(OP_WRITE, 255, 255, 0, 0, 254);
        push_req(OP_POINT, 255, 255, 0, 0, 0);
        // Equal endpoints on a blocked cell still report clear.
        push_req(OP_SEGMENT, 0, 0, 0, 0, 0);
        push_req(OP_SEGMENT, 0, 0, 255, 255, 0);
        push_req(OP_SEGMENT, 255, 255, 1, 1, 0);
        push_req(OP_WRITE, 100, 7, 0, 0, 199);
        push_req(OP_SEGMENT, 0, 7, 255, 7, 0);
        push_req(OP_SEGMENT, 255, 8, 0, 6, 0);
        push_req(OP_WRITE, 100, 7, 0, 0, 200);
        push_req(OP_SEGMENT, 255, 7, 0, 7, 0);
        push_req(OP_WRITE, 30, 60, 0, 0, 10);
        push_req(OP_SEGMENT, 20, 50, 40, 70, 0);
        push_req(OP_SEGMENT, 30, 0, 30, 255, 0);
        push_req(OP_SEGMENT, 0, 61, 255, 59, 0);
        push_req(OP_UNUSED, 255, 255, 255, 255, 255);
        push_req(OP_UNUSED, 30, 60, 0, 0, 0);
        push_req(OP_POINT, 30, 60, 0, 0, 0);
        push_req(OP_WRITE, 255, 0, 0, 0, 255);
        push_req(OP_SEGMENT, 255, 0, 0, 255, 0);
    endtask

    // Obstacle-then-test sequences along the planned segment (45 of 100 picks), the rest loose requests.
    task automatic plan_random(input int n);
        int planned, ax, ay, bx, by, ox, oy, pick, obstacles;
        planned = 0;
        while (planned < n)
        begin
            pick = $urandom_range(0, 99);
            ax = rand_coord(cols_used());
            ay = rand_coord(rows_used());
            bx = rand_coord(cols_used());
            by = rand_coord(rows_used());
            if (pick < 45)
            begin
                obstacles = $urandom_range(0, 2);
                ox = ax;
                oy = ay;
                repeat (obstacles)
                begin
                    pick = $urandom_range(0, 16);
                    ox = ax + ((bx - ax) * pick) / 16;
                    oy = ay + ((by - ay) * pick) / 16;
                    push_req(OP_WRITE, ox, oy, $urandom_range(0, 255), $urandom_range(0, 255),
                             pick_value(cfg_line_thr));
                    planned++;
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    push_req(OP_SEGMENT, ax, ay, bx, by, $urandom_range(0, 255));
                end
                else
                begin
                    push_req(OP_SEGMENT, bx, by, ax, ay, $urandom_range(0, 255));
                end
                planned++;
                if (obstacles != 0 && $urandom_range(0, 2) == 0)
                begin
                    push_req(OP_POINT, ox, oy, $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
                    planned++;
                end
            end
            else if (pick < 65)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    bx = ax;
                    by = ay;
                end
                push_req(OP_SEGMENT, ax, ay, bx, by, $urandom_range(0, 255));
                planned++;
            end
            else if (pick < 80)
            begin
                push_req(OP_POINT, ax, ay, bx, by, $urandom_range(0, 255));
                planned++;
            end
            else if (pick < 95)
            begin
                push_req(OP_WRITE, ax, ay, bx, by,
                         pick_value(($urandom_range(0, 1) == 1) ? cfg_point_thr : cfg_line_thr));
                planned++;
            end
            else
            begin
                push_req(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
                planned++;
            end
        end
    endtask

    initial
    begin
        int w, h, s;
        for (int i = 0; i < GRID_W * GRID_H; i++)
        begin
            occ_model[i] = CELL_RESET;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values first, then a sweep of fixed and random settings.
        plan_directed();
        wait_for_drain();
        program_map_config(16, 16, 1, 128, 128);
        plan_random(170);
        wait_for_drain();
        program_map_config(256, 256, 3, 0, 0);
        plan_random(170);
        wait_for_drain();
        program_map_config(1, 1, 255, 255, 255);
        plan_random(60);
        wait_for_drain();
        program_map_config(40, 200, 2, 100, 50);
        plan_random(170);
        wait_for_drain();
        // A zero step walks one cell at a time.
        program_map_config(256, 256, 0, 180, 90);
        plan_random(170);
        wait_for_drain();
        // Zero size leaves no cell in the map.
        program_map_config(0, 0, 5, 200, 200);
        plan_random(40);
        wait_for_drain();
        // Sizes above the map dimensions are clamped.
        program_map_config(511, 300, 7, 255, 1);
        plan_random(170);
        wait_for_drain();
        repeat (5)
        begin
            w = $urandom_range(1, 256);
            h = $urandom_range(1, 256);
            s = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 4);
            program_map_config(w, h, s, $urandom_range(0, 255), $urandom_range(0, 255));
            plan_random(170);
            wait_for_drain();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d writes, %0d point tests (%0d clear), %0d segment tests (%0d clear),",
                 n_writes, n_points, n_points_clear, n_segments, n_segments_clear);
        $display("and %0d unused-code requests over %0d register settings after reset defaults.",
                 n_unused, n_settings);
        if (fail_count == 0)
        begin
            $display("tb_grid_segment_obstacle_check passed");
        end
        else
        begin
            $display("tb_grid_segment_obstacle_check failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/gsoc_pkg.sv
rtl/gsoc_div.sv
rtl/gsoc_datapath.sv
rtl/gsoc_ctrl.sv
rtl/grid_segment_obstacle_check.sv
bench/tb_grid_segment_obstacle_check.sv
